FILE: rtl/core/nrl_pkg.sv
// Package for the record rotation log: sizes, command codes and the
// control and status types shared by the controller and the datapath.
// Depends on nothing.
`default_nettype none

package nrl_pkg;

	localparam int MAX_SLOTS    = 64;
	localparam int RECORD_BYTES = 16;
	localparam int REC_W        = RECORD_BYTES * 8;
	localparam int HALF_W       = REC_W / 2;
	localparam int SLOT_W       = $clog2(MAX_SLOTS);
	localparam int CNT_W        = $clog2(MAX_SLOTS + 1);
	localparam int CMD_W        = 2;
	localparam int BLK_W        = 7;

	localparam logic [BLK_W-1:0] REGION_RESET = BLK_W'(64);
	localparam logic [REC_W-1:0] BLANK_RECORD = {REC_W{1'b1}};

	typedef enum logic [CMD_W-1:0] {
		CMD_READ   = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_LOAD   = 2'd2,
		CMD_ALT    = 2'd3
	} cmd_e_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic direct;
		logic scan_done;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/nrl_if.sv
// Channel interfaces of the record rotation log: request, response and
// the configuration write channel. Depends on nrl_pkg.
`default_nettype none

interface nrl_req_if import nrl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [SLOT_W-1:0] slot;
	logic [HALF_W-1:0] entry_low;
	logic [HALF_W-1:0] entry_high;

	modport source (output valid, command, slot, entry_low, entry_high, input ready);
	modport sink (input valid, command, slot, entry_low, entry_high, output ready);
endinterface

interface nrl_rsp_if import nrl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              status;
	logic [HALF_W-1:0] record_low;
	logic [HALF_W-1:0] record_high;
	logic [SLOT_W-1:0] used_slot;
	logic              wrapped;

	modport source (output valid, status, record_low, record_high, used_slot, wrapped,
		input ready);
	modport sink (input valid, status, record_low, record_high, used_slot, wrapped,
		output ready);
endinterface

interface nrl_cfg_if import nrl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] region_blocks;

	modport source (output valid, region_blocks, input ready);
	modport sink (input valid, region_blocks, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nrl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module nrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/nrl_dp.sv
// Datapath of the record rotation log: record store, valid bits, region
// scan pipeline, append and load writes and the response register.
// Depends on nrl_pkg and nrl_ram.
`default_nettype none

module nrl_dp import nrl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output      dp_sts_t           sts,
	input  wire logic              cfg_valid,
	input  wire logic [BLK_W-1:0]  cfg_blocks,
	input  wire logic [CMD_W-1:0]  req_command,
	input  wire logic [SLOT_W-1:0] req_slot,
	input  wire logic [HALF_W-1:0] req_entry_low,
	input  wire logic [HALF_W-1:0] req_entry_high,
	input  wire logic              rsp_ready,
	output      logic              rsp_valid,
	output      logic              rsp_status,
	output      logic [HALF_W-1:0] rsp_record_low,
	output      logic [HALF_W-1:0] rsp_record_high,
	output      logic [SLOT_W-1:0] rsp_used_slot,
	output      logic              rsp_wrapped
);

	logic [BLK_W-1:0]     blocks_q;
	logic [MAX_SLOTS-1:0] valid_q;
	logic [MAX_SLOTS-1:0] valid_next;
	logic                 out_valid_q;
	logic                 chk_vld_s1;

	logic [CMD_W-1:0]     cmd_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [REC_W-1:0]     entry_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     chk_s1;
	logic                 vld_s1;
	logic [CNT_W-1:0]     first_q;
	logic [REC_W-1:0]     last_q;

	logic [CNT_W-1:0]     region_n;
	logic                 rd_en;
	logic [REC_W-1:0]     rd_data;
	logic                 blank;
	logic [CNT_W-1:0]     chk_next;
	logic                 scan_done;

	logic                 is_load;
	logic                 is_append;
	logic                 uninit;
	logic                 load_ok;
	logic                 wrap;
	logic [SLOT_W-1:0]    app_addr;
	logic                 wr_en;
	logic [SLOT_W-1:0]    wr_addr;

	logic                 res_status;
	logic [REC_W-1:0]     res_record;
	logic [SLOT_W-1:0]    res_slot;

	assign region_n = (blocks_q > BLK_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(blocks_q);

	assign rd_en    = cmd.scan && (idx_q < region_n);
	assign blank    = !vld_s1 || (rd_data == BLANK_RECORD);
	assign chk_next = chk_s1 + CNT_W'(1);
	assign scan_done = chk_vld_s1 && (blank || (chk_next >= region_n));

	assign sts.direct    = (req_command == CMD_LOAD) || (region_n == CNT_W'(0));
	assign sts.scan_done = scan_done;
	assign sts.out_free  = !out_valid_q || rsp_ready;

	nrl_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_SLOTS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (entry_q),
		.re    (rd_en),
		.raddr (idx_q[SLOT_W-1:0]),
		.rdata (rd_data)
	);

	always_comb begin
		is_load   = (cmd_q == CMD_LOAD);
		is_append = (cmd_q == CMD_APPEND);
		uninit    = (first_q == CNT_W'(0));
		load_ok   = (CNT_W'(slot_q) < CNT_W'(MAX_SLOTS));
		wrap      = is_append && !uninit && (first_q >= region_n);
		app_addr  = wrap ? SLOT_W'(0) : first_q[SLOT_W-1:0];
		wr_en     = cmd.commit && (is_load ? load_ok : (is_append && !uninit));
		wr_addr   = is_load ? slot_q : app_addr;

		res_status = 1'b0;
		res_record = entry_q;
		res_slot   = app_addr;
		if (is_load) begin
			res_status = !load_ok;
			res_record = load_ok ? entry_q : '0;
			res_slot   = slot_q;
		end else if (uninit) begin
			res_status = 1'b1;
			res_record = '0;
			res_slot   = '0;
		end else if (!is_append) begin
			res_record = last_q;
			res_slot   = SLOT_W'(first_q - CNT_W'(1));
		end
	end

	always_comb begin
		valid_next = valid_q;
		if (wr_en) begin
			if (wrap) begin
				for (int j = 0; j < MAX_SLOTS; j++) begin
					if (CNT_W'(j) < region_n) begin
						valid_next[j] = 1'b0;
					end
				end
			end
			valid_next[wr_addr] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q    <= REGION_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			chk_vld_s1  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				blocks_q <= cfg_blocks;
			end
			valid_q <= valid_next;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			chk_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= req_command;
			slot_q  <= req_slot;
			entry_q <= {req_entry_high, req_entry_low};
			idx_q   <= '0;
			first_q <= '0;
		end
		if (rd_en) begin
			idx_q  <= idx_q + CNT_W'(1);
			chk_s1 <= idx_q;
			vld_s1 <= valid_q[idx_q[SLOT_W-1:0]];
		end
		if (chk_vld_s1 && !blank) begin
			last_q <= rd_data;
		end
		if (scan_done) begin
			first_q <= blank ? chk_s1 : chk_next;
		end
		if (cmd.commit) begin
			rsp_status      <= res_status;
			rsp_record_low  <= res_record[HALF_W-1:0];
			rsp_record_high <= res_record[REC_W-1:HALF_W];
			rsp_used_slot   <= res_slot;
			rsp_wrapped     <= wrap;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/nrl_ctrl.sv
// Controller of the record rotation log: takes a request, runs the region
// scan and triggers the commit. Depends on nrl_pkg.
`default_nettype none

module nrl_ctrl import nrl_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output      logic    req_ready,
	input  wire dp_sts_t sts,
	output      dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_comb begin
		req_ready   = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_SCAN: begin
				cmd.scan = !sts.scan_done;
			end
			ST_COMMIT: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= sts.direct ? ST_COMMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/nvram_record_rotation_log.sv
// Record rotation log: a region of 16-byte records appended in turn, with
// erase on wrap. Each request reads the current record, appends a record or
// loads one raw slot, and produces exactly one response.
// A write on cfg sets the region size in slots; it is always accepted and
// belongs in idle periods only.
// The response to a load, or to any request while the region size is zero,
// skips the scan: the request goes straight to the commit state, which
// writes the response register. A read or an append scans the region one
// slot per cycle from slot 0 through a registered store read, stopping at
// the first blank slot or at the end of the region. One request is in
// flight at a time; the next is taken as soon as the previous result sits in
// the response register.
// Reset sets the region size to 64 and marks every slot erased through a
// valid bit per slot, so no clearing pass runs. When the receiver stalls,
// the response holds and the block waits before committing the next one.
// Depends on nrl_pkg, nrl_if, nrl_ram, nrl_dp and nrl_ctrl.
`default_nettype none

module nvram_record_rotation_log import nrl_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	nrl_cfg_if.sink  cfg,
	nrl_req_if.sink  req,
	nrl_rsp_if.source rsp
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	assign cfg.ready = 1'b1;

	nrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	nrl_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (dp_cmd),
		.sts             (dp_sts),
		.cfg_valid       (cfg.valid),
		.cfg_blocks      (cfg.region_blocks),
		.req_command     (req.command),
		.req_slot        (req.slot),
		.req_entry_low   (req.entry_low),
		.req_entry_high  (req.entry_high),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_status      (rsp.status),
		.rsp_record_low  (rsp.record_low),
		.rsp_record_high (rsp.record_high),
		.rsp_used_slot   (rsp.used_slot),
		.rsp_wrapped     (rsp.wrapped)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.commit |-> (!rsp.valid || rsp.ready))
		else $error("pending response overwritten");

	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(dp_cmd.commit))
		else $error("response raised without a commit");

endmodule

`default_nettype wire
